>>> rtl/core/tsrt_pkg.sv
// shared types, constants and helpers of the reassembly tracker
// no dependencies
package tsrt_pkg;

  localparam int unsigned SegmentSlots = 16;
  localparam int unsigned SlotW        = $clog2(SegmentSlots);
  localparam int unsigned IdxW         = $clog2(SegmentSlots + 1);

  localparam logic [31:0] InitSeqReset = 32'd0;
  localparam logic [15:0] WinSizeReset = 16'd4096;

  typedef enum logic {
    CfgInitSeq = 1'b0,
    CfgWinSize = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StatAdvanced = 3'd0,
    StatStored   = 3'd1,
    StatOutside  = 3'd2,
    StatFull     = 3'd3,
    StatTooLarge = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CellHold,
    CellClear,
    CellInsert,
    CellMark,
    CellPull
  } cell_op_e;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StCompact,
    StWalk
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] start;
    logic [15:0] len;
  } seg_t;

  typedef struct packed {
    cell_op_e    op;
    logic [31:0] seq;
    logic [15:0] len;
    logic [31:0] nb;
  } cell_bus_t;

  typedef struct packed {
    logic take_new;
    logic from_prev;
    logic from_next;
  } cell_sel_t;

  function automatic logic precedes(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

>>> rtl/core/tsrt_cell.sv
// one slot of the sorted segment chain
// depends on tsrt_pkg
module tsrt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsrt_pkg::cell_bus_t bus_i,
  input  tsrt_pkg::cell_sel_t sel_i,
  input  tsrt_pkg::seg_t    prev_i,
  input  tsrt_pkg::seg_t    next_i,
  output tsrt_pkg::seg_t    seg_o,
  output logic              match_o
);

  logic        valid_q, valid_d;
  logic [31:0] start_q, start_d;
  logic [15:0] len_q, len_d;
  logic [31:0] seg_end;
  logic [31:0] new_end;
  logic [31:0] diff;
  logic [15:0] trim_len;

  assign seg_end = start_q + {16'd0, len_q};
  assign new_end = bus_i.seq + {16'd0, bus_i.len};
  assign diff    = start_q - bus_i.seq;
  assign match_o = valid_q & tsrt_pkg::precedes(bus_i.seq, start_q);
  assign seg_o   = '{valid: valid_q, start: start_q, len: len_q};

  always_comb begin
    trim_len = bus_i.len;
    if (valid_q && tsrt_pkg::precedes(start_q, new_end)) begin
      trim_len = diff[15:0];
    end
  end

  always_comb begin
    logic [31:0] cut;
    cut     = seg_end - bus_i.nb;
    valid_d = valid_q;
    start_d = start_q;
    len_d   = len_q;
    unique case (bus_i.op)
      tsrt_pkg::CellClear: valid_d = 1'b0;
      tsrt_pkg::CellInsert: begin
        if (sel_i.take_new) begin
          valid_d = 1'b1;
          start_d = bus_i.seq;
          len_d   = trim_len;
        end else if (sel_i.from_prev) begin
          valid_d = prev_i.valid;
          start_d = prev_i.start;
          len_d   = prev_i.len;
        end
      end
      tsrt_pkg::CellMark: begin
        if (valid_q) begin
          if (!tsrt_pkg::precedes(bus_i.nb, seg_end)) begin
            valid_d = 1'b0;
          end else if (tsrt_pkg::precedes(start_q, bus_i.nb)) begin
            start_d = bus_i.nb;
            len_d   = cut[15:0];
          end
        end
      end
      tsrt_pkg::CellPull: begin
        if (sel_i.from_next) begin
          valid_d = next_i.valid;
          start_d = next_i.start;
          len_d   = next_i.len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
  end

endmodule

>>> rtl/core/tcp_segment_reassembly_tracker_core.sv
// top level of the tcp reassembly tracker: control, window check, run walk
// depends on tsrt_pkg and tsrt_cell
//
// A request beat is taken when start_i is high and busy_o is low; its single
// result appears on the result ports for one cycle with done_o high and must
// be taken then, the receiver cannot stall. Rejected or empty requests end in
// the check state. An arrival that is stored goes from the check state to the
// run walk; a consume that moves the base goes from the check state through
// the compaction steps after dropped slots to the run walk. The walk visits
// slots one per cycle from the head of the chain, at most 16 of them.
module tcp_segment_reassembly_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [31:0] seq_num_i,
  input  logic [15:0] byte_count_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] receive_next_o,
  output logic [15:0] ready_bytes_o,
  output logic        send_ack_o
);

  localparam int unsigned N = tsrt_pkg::SegmentSlots;

  tsrt_pkg::state_e state_q, state_d;
  logic [15:0] wsize_q;
  logic [31:0] base_q, base_d;
  logic [31:0] ne_q, ne_d;
  logic [31:0] old_ne_q, old_ne_d;
  logic [31:0] end_q, end_d;
  logic [tsrt_pkg::IdxW-1:0] idx_q, idx_d;
  logic        req_q;
  logic [31:0] seq_q;
  logic [15:0] cnt_q;

  logic        done_q;
  logic [2:0]  status_q;
  logic [31:0] rnext_q;
  logic [15:0] ready_q;
  logic        ack_q;

  logic        res_set;
  logic [2:0]  res_status;
  logic [31:0] res_ne;
  logic [15:0] res_ready;
  logic        res_ack;

  tsrt_pkg::cell_bus_t bus;
  tsrt_pkg::cell_sel_t sel [N];
  tsrt_pkg::seg_t      segs [N];
  logic [N-1:0]        match;

  tsrt_pkg::seg_t cur;
  logic [31:0]    cur_end;
  logic [31:0]    limit;
  logic [31:0]    last_byte;
  logic [31:0]    ready32;
  logic [31:0]    run;
  logic [15:0]    run_cap;
  logic           win_ok;
  logic           packed_ok;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      tsrt_pkg::seg_t prev_seg, next_seg;
      if (g == 0) begin : g_first
        assign prev_seg = '0;
      end else begin : g_mid
        assign prev_seg = segs[g-1];
      end
      if (g == N - 1) begin : g_last
        assign next_seg = '0;
      end else begin : g_rest
        assign next_seg = segs[g+1];
      end
      tsrt_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .bus_i   (bus),
        .sel_i   (sel[g]),
        .prev_i  (prev_seg),
        .next_i  (next_seg),
        .seg_o   (segs[g]),
        .match_o (match[g])
      );
    end
  endgenerate

  // insert position and hole search along the chain
  always_comb begin
    logic ahead, hole;
    ahead = 1'b0;
    hole  = 1'b0;
    packed_ok = 1'b1;
    for (int i = 0; i < N; i++) begin
      sel[i].take_new  = !ahead && (match[i] || !segs[i].valid);
      sel[i].from_prev = ahead;
      ahead            = ahead || match[i] || !segs[i].valid;
      hole             = hole || !segs[i].valid;
      sel[i].from_next = hole;
      if (hole && segs[i].valid) begin
        packed_ok = 1'b0;
      end
    end
  end

  assign cur       = (idx_q == tsrt_pkg::IdxW'(N)) ? '0 : segs[idx_q[tsrt_pkg::SlotW-1:0]];
  assign cur_end   = cur.start + {16'd0, cur.len};
  assign limit     = base_q + {16'd0, wsize_q};
  assign last_byte = seq_q + {16'd0, cnt_q} - 32'd1;
  assign ready32   = ne_q - base_q;
  assign run       = end_q - base_q;
  assign run_cap   = (|run[31:16]) ? 16'hFFFF : run[15:0];

  always_comb begin
    if (cnt_q == 16'd0) begin
      if (wsize_q == 16'd0) begin
        win_ok = (seq_q == ne_q);
      end else begin
        win_ok = !tsrt_pkg::precedes(seq_q, ne_q) && tsrt_pkg::precedes(seq_q, limit);
      end
    end else begin
      win_ok = (wsize_q != 16'd0) && !tsrt_pkg::precedes(seq_q, ne_q)
               && tsrt_pkg::precedes(last_byte, limit);
    end
  end

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    ne_d       = ne_q;
    old_ne_d   = old_ne_q;
    end_d      = end_q;
    idx_d      = idx_q;
    bus.op     = tsrt_pkg::CellHold;
    bus.seq    = seq_q;
    bus.len    = cnt_q;
    bus.nb     = base_q + {16'd0, cnt_q};
    res_set    = 1'b0;
    res_status = tsrt_pkg::StatAdvanced;
    res_ne     = ne_q;
    res_ready  = ready32[15:0];
    res_ack    = 1'b0;
    unique case (state_q)
      tsrt_pkg::StIdle: begin
        if (cfg_we_i && cfg_idx_i == tsrt_pkg::CfgInitSeq) begin
          bus.op = tsrt_pkg::CellClear;
          base_d = cfg_data_i;
          ne_d   = cfg_data_i;
        end else if (start_i) begin
          state_d = tsrt_pkg::StCheck;
        end
      end
      tsrt_pkg::StCheck: begin
        state_d = tsrt_pkg::StIdle;
        res_set = 1'b1;
        if (!req_q) begin
          if (!win_ok) begin
            res_status = tsrt_pkg::StatOutside;
          end else if (cnt_q == 16'd0) begin
            res_status = tsrt_pkg::StatStored;
            res_ack    = 1'b1;
          end else if (segs[N-1].valid) begin
            res_status = tsrt_pkg::StatFull;
          end else begin
            res_set  = 1'b0;
            bus.op   = tsrt_pkg::CellInsert;
            old_ne_d = ne_q;
            end_d    = base_q;
            idx_d    = '0;
            state_d  = tsrt_pkg::StWalk;
          end
        end else begin
          if ({16'd0, cnt_q} > ready32) begin
            res_status = tsrt_pkg::StatTooLarge;
          end else if (cnt_q != 16'd0) begin
            res_set = 1'b0;
            bus.op  = tsrt_pkg::CellMark;
            base_d  = bus.nb;
            old_ne_d = ne_q;
            state_d = tsrt_pkg::StCompact;
          end
        end
      end
      tsrt_pkg::StCompact: begin
        if (packed_ok) begin
          end_d   = base_q;
          idx_d   = '0;
          state_d = tsrt_pkg::StWalk;
        end else begin
          bus.op = tsrt_pkg::CellPull;
        end
      end
      tsrt_pkg::StWalk: begin
        if (!cur.valid || tsrt_pkg::precedes(end_q, cur.start)) begin
          ne_d       = base_q + {16'd0, run_cap};
          res_set    = 1'b1;
          res_ne     = ne_d;
          res_ready  = run_cap;
          res_ack    = !req_q;
          res_status = (req_q || ne_d != old_ne_q) ? tsrt_pkg::StatAdvanced
                                                   : tsrt_pkg::StatStored;
          state_d    = tsrt_pkg::StIdle;
        end else begin
          if (!tsrt_pkg::precedes(cur_end, end_q)) begin
            end_d = cur_end;
          end
          idx_d = idx_q + tsrt_pkg::IdxW'(1);
        end
      end
      default: state_d = tsrt_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsrt_pkg::StIdle;
      wsize_q <= tsrt_pkg::WinSizeReset;
      base_q  <= tsrt_pkg::InitSeqReset;
      ne_q    <= tsrt_pkg::InitSeqReset;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      ne_q    <= ne_d;
      done_q  <= res_set;
      if (cfg_we_i && cfg_idx_i == tsrt_pkg::CfgWinSize) begin
        wsize_q <= cfg_data_i[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    old_ne_q <= old_ne_d;
    end_q    <= end_d;
    idx_q    <= idx_d;
    if (state_q == tsrt_pkg::StIdle && start_i) begin
      req_q <= req_type_i;
      seq_q <= seq_num_i;
      cnt_q <= byte_count_i;
    end
    if (res_set) begin
      status_q <= res_status;
      rnext_q  <= res_ne;
      ready_q  <= res_ready;
      ack_q    <= res_ack;
    end
  end

  assign busy_o         = (state_q != tsrt_pkg::StIdle);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign receive_next_o = rnext_q;
  assign ready_bytes_o  = ready_q;
  assign send_ack_o     = ack_q;

endmodule

>>> dv/tcp_segment_reassembly_tracker_core_checker.sv
// scoreboard of the reassembly tracker: tracks config writes and request beats,
// predicts each result and compares it with done_o beats; depends on tsrt_pkg
`timescale 1ns / 1ps
module tcp_segment_reassembly_tracker_core_checker
  import tsrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic        req_type_i,
  input  logic [31:0] seq_num_i,
  input  logic [15:0] byte_count_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        done_o,
  input  logic [2:0]  status_o,
  input  logic [31:0] receive_next_o,
  input  logic [15:0] ready_bytes_o,
  input  logic        send_ack_o,
  output int          errors_o,
  output int          pending_o
);

  typedef struct {
    status_e     status;
    logic [31:0] rcv_next;
    logic [15:0] ready;
    logic        ack;
  } reasm_result_t;

  reasm_result_t result_q[$];

  logic [31:0] seg_start[SegmentSlots];
  logic [15:0] seg_len[SegmentSlots];
  int          seg_cnt;
  logic [31:0] win_base;
  logic [31:0] rcv_next;
  logic [15:0] wnd_span;

  assign pending_o = result_q.size();

  function automatic bit is_earlier(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic [15:0] head_run();
    logic [31:0] run_end;
    logic [31:0] seg_end;
    logic [31:0] span;
    run_end = win_base;
    for (int i = 0; i < seg_cnt; i++) begin
      if (is_earlier(run_end, seg_start[i])) break;
      seg_end = seg_start[i] + seg_len[i];
      if (!is_earlier(seg_end, run_end)) run_end = seg_end;
    end
    span = run_end - win_base;
    return (span > 32'd65535) ? 16'hffff : span[15:0];
  endfunction

  function automatic bit in_window(logic [31:0] seq, logic [15:0] len);
    logic [31:0] limit;
    limit = win_base + wnd_span;
    if (len == 0) begin
      if (wnd_span == 0) return seq == rcv_next;
      return !is_earlier(seq, rcv_next) && is_earlier(seq, limit);
    end
    if (wnd_span == 0) return 0;
    return !is_earlier(seq, rcv_next) && is_earlier(seq + len - 32'd1, limit);
  endfunction

  function automatic void store_segment(logic [31:0] seq, logic [15:0] len);
    int          pos;
    logic [31:0] trimmed;
    pos = 0;
    trimmed = {16'd0, len};
    while (pos < seg_cnt && !is_earlier(seq, seg_start[pos])) pos++;
    if (pos < seg_cnt && is_earlier(seg_start[pos], seq + len))
      trimmed = seg_start[pos] - seq;
    for (int i = seg_cnt; i > pos; i--) begin
      seg_start[i] = seg_start[i-1];
      seg_len[i]   = seg_len[i-1];
    end
    seg_start[pos] = seq;
    seg_len[pos]   = trimmed[15:0];
    seg_cnt++;
  endfunction

  function automatic void drop_head(logic [15:0] n);
    logic [31:0] nb;
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] l;
    int          k;
    nb = win_base + n;
    k = 0;
    for (int i = 0; i < seg_cnt; i++) begin
      s = seg_start[i];
      e = s + seg_len[i];
      if (!is_earlier(nb, e)) continue;
      if (is_earlier(s, nb)) s = nb;
      l = e - s;
      seg_start[k] = s;
      seg_len[k]   = l[15:0];
      k++;
    end
    seg_cnt = k;
    win_base = nb;
  endfunction

  function automatic reasm_result_t predict(logic req, logic [31:0] seq, logic [15:0] cnt);
    reasm_result_t r;
    logic [31:0]   prev;
    logic [31:0]   d;
    r.ack = 0;
    if (req == 1'b0) begin
      if (!in_window(seq, cnt)) begin
        r.status = StatOutside;
      end else if (cnt == 0) begin
        r.status = StatStored;
        r.ack = 1;
      end else if (seg_cnt >= SegmentSlots) begin
        r.status = StatFull;
      end else begin
        prev = rcv_next;
        store_segment(seq, cnt);
        rcv_next = win_base + head_run();
        r.status = (rcv_next != prev) ? StatAdvanced : StatStored;
        r.ack = 1;
      end
    end else begin
      if (cnt > head_run()) begin
        r.status = StatTooLarge;
      end else begin
        if (cnt != 0) drop_head(cnt);
        rcv_next = win_base + head_run();
        r.status = StatAdvanced;
      end
    end
    d = rcv_next - win_base;
    r.rcv_next = rcv_next;
    r.ready = d[15:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reasm_result_t exp_r;
    if (!rst_ni) begin
      seg_cnt  = 0;
      win_base = InitSeqReset;
      rcv_next = InitSeqReset;
      wnd_span = WinSizeReset;
      errors_o = 0;
      result_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgInitSeq) begin
          seg_cnt  = 0;
          win_base = cfg_data_i;
          rcv_next = cfg_data_i;
        end else begin
          wnd_span = cfg_data_i[15:0];
        end
      end
      if (done_o) begin
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors_o++;
        end else begin
          exp_r = result_q.pop_front();
          if (status_o != exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            errors_o++;
          end
          if (receive_next_o != exp_r.rcv_next) begin
            $error("receive_next: expected %h, got %h", exp_r.rcv_next, receive_next_o);
            errors_o++;
          end
          if (ready_bytes_o != exp_r.ready) begin
            $error("ready_bytes: expected %0d, got %0d", exp_r.ready, ready_bytes_o);
            errors_o++;
          end
          if (send_ack_o != exp_r.ack) begin
            $error("send_ack: expected %0d, got %0d", exp_r.ack, send_ack_o);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_o)
        result_q.push_back(predict(req_type_i, seq_num_i, byte_count_i));
    end
  end

endmodule

>>> dv/tcp_segment_reassembly_tracker_core_test.sv
// testbench top of the reassembly tracker: clock, reset, config phases and
// request stimulus; depends on tsrt_pkg, the core and its checker
`timescale 1ns / 1ps
module tcp_segment_reassembly_tracker_core_test;
  import tsrt_pkg::*;

  localparam logic ReqArrive  = 1'b0;
  localparam logic ReqConsume = 1'b1;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic        req_type_i = 0;
  logic [31:0] seq_num_i = 0;
  logic [15:0] byte_count_i = 0;
  logic        cfg_we_i = 0;
  logic        cfg_idx_i = 0;
  logic [31:0] cfg_data_i = 0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] receive_next_o;
  logic [15:0] ready_bytes_o;
  logic        send_ack_o;
  int          errors;
  int          pending;

  logic [31:0] seen_next;
  logic [15:0] seen_ready;
  logic [15:0] cur_win;

  always #4 clk_i = ~clk_i;

  tcp_segment_reassembly_tracker_core u_top (.*);

  tcp_segment_reassembly_tracker_core_checker u_chk (
    .errors_o (errors),
    .pending_o(pending),
    .*
  );

  // last observed head of the stream, used only to aim the stimulus
  always @(posedge clk_i) begin
    if (done_o) begin
      seen_next  = receive_next_o;
      seen_ready = ready_bytes_o;
    end
  end

  task automatic send(logic req, logic [31:0] seq, logic [15:0] cnt);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1;
    req_type_i   <= req;
    seq_num_i    <= seq;
    byte_count_i <= cnt;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic settle();
    start_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [31:0] data);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_item();
    int          pick;
    int          reach;
    logic [31:0] base;
    base  = seen_next - seen_ready;
    reach = (cur_win > 600) ? 600 : cur_win;
    pick  = $urandom_range(0, 99);
    if (pick < 55)
      send(ReqArrive, seen_next + $urandom_range(0, reach), 16'($urandom_range(1, 200)));
    else if (pick < 60)
      send(ReqArrive, seen_next + $urandom_range(0, reach), 16'd0);
    else if (pick < 65)
      send(ReqArrive, base + cur_win - $urandom_range(0, 300), 16'($urandom_range(1, 400)));
    else if (pick < 80)
      send(ReqConsume, $urandom, 16'($urandom_range(0, seen_ready)));
    else if (pick < 85)
      send(ReqConsume, $urandom, 16'(seen_ready + $urandom_range(1, 50)));
    else
      send(1'($urandom_range(0, 1)), $urandom, 16'($urandom));
  endtask

  initial begin
    logic [31:0] init_seq[5];
    logic [15:0] win_set[5];
    init_seq = '{32'd0, 32'hffff_ff00, 32'h7fff_fff0, 32'hffff_ffff, 32'h0};
    win_set  = '{16'd4096, 16'hffff, 16'd1, 16'd0, 16'd300};
    init_seq[4] = $urandom;
    seen_next  = InitSeqReset;
    seen_ready = 0;
    cur_win    = WinSizeReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // directed: in order, out of order, window edges, empty, consume limits
    send(ReqArrive, 32'd100, 16'd50);
    send(ReqArrive, 32'd0, 16'd100);
    send(ReqArrive, 32'd0, 16'd0);
    send(ReqArrive, 32'd150, 16'd0);
    send(ReqArrive, 32'd4095, 16'd1);
    send(ReqArrive, 32'd4096, 16'd1);
    send(ReqArrive, 32'hffff_ffff, 16'd1);
    send(ReqArrive, 32'd140, 16'd30);
    send(ReqConsume, 32'hffff_ffff, 16'd171);
    send(ReqConsume, 32'd0, 16'd0);
    send(ReqConsume, 32'd0, 16'd120);
    send(ReqArrive, 32'd200, 16'hffff);
    for (int i = 0; i < 13; i++) send(ReqArrive, 32'd300 + 20 * i, 16'd5);
    send(ReqArrive, 32'd1000, 16'd5);
    send(ReqConsume, 32'd0, 16'hffff);
    for (int i = 0; i < 300; i++) random_item();

    for (int p = 0; p < 5; p++) begin
      settle();
      write_cfg(CfgWinSize, {16'h0, win_set[p]});
      write_cfg(CfgInitSeq, init_seq[p]);
      cur_win    = win_set[p];
      seen_next  = init_seq[p];
      seen_ready = 0;
      if (win_set[p] == 16'hffff) send(ReqArrive, init_seq[p], 16'hffff);
      for (int i = 0; i < 240; i++) random_item();
    end
    settle();
    if (errors == 0)
      $display("tcp_segment_reassembly_tracker_core_test: clean");
    else
      $display("tcp_segment_reassembly_tracker_core_test: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tcp_segment_reassembly_tracker_core_test: errors");
    $finish;
  end

endmodule
